/* rtl/qmr_pkg.sv */
// qmr_pkg: shared types and constants of the quaternion multiply / rotate block
// no dependencies; used by every module under rtl
`default_nettype none

package qmr_pkg;

  // Q15.16 component and its derived widths
  localparam int COMP_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * COMP_W;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int SUM_W  = TERM_W + 2;

  // operation kinds
  localparam logic [1:0] KIND_MUL  = 2'd0;
  localparam logic [1:0] KIND_ROT  = 2'd1;
  localparam logic [1:0] KIND_RROT = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // component order: w, x, y, z
  typedef comp_t quat_t [4];
  // term [i][j] = p[i] * q[j], already shifted right by the fraction width
  typedef term_t terms_t [4][4];

  localparam comp_t COMP_MAX = 32'sh7fff_ffff;
  localparam comp_t COMP_MIN = 32'sh8000_0000;
  localparam sum_t  SUM_MAX  = SUM_W'(COMP_MAX);
  localparam sum_t  SUM_MIN  = SUM_W'(COMP_MIN);

endpackage

`default_nettype wire

/* rtl/qmr_mul_stage.sv */
// qmr_mul_stage: sixteen registered 32x32 signed products of two quaternions
// depends on qmr_pkg
`default_nettype none

module qmr_mul_stage
  import qmr_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  quat_t  p,
  input  quat_t  q,
  output terms_t terms_r
);

  // every cross product, truncated toward minus infinity by the fraction shift
  for (genvar i = 0; i < 4; i++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      logic signed [PROD_W-1:0] prod;

      assign prod = PROD_W'(p[i]) * PROD_W'(q[j]);

      always_ff @(posedge clk) begin
        if (en) begin
          terms_r[i][j] <= prod[PROD_W-1:FRAC_W];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/qmr_sum_stage.sv */
// qmr_sum_stage: Hamilton sums of the product terms, saturated and registered
// depends on qmr_pkg
`default_nettype none

module qmr_sum_stage
  import qmr_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  terms_t     terms,
  output quat_t      sum_r,
  output logic [3:0] sat_r
);

  sum_t s [4];

  // Hamilton product signs
  always_comb begin
    s[0] = SUM_W'(terms[0][0]) - SUM_W'(terms[1][1])
         - SUM_W'(terms[2][2]) - SUM_W'(terms[3][3]);
    s[1] = SUM_W'(terms[0][1]) + SUM_W'(terms[1][0])
         + SUM_W'(terms[2][3]) - SUM_W'(terms[3][2]);
    s[2] = SUM_W'(terms[0][2]) - SUM_W'(terms[1][3])
         + SUM_W'(terms[2][0]) + SUM_W'(terms[3][1]);
    s[3] = SUM_W'(terms[0][3]) + SUM_W'(terms[1][2])
         - SUM_W'(terms[2][1]) + SUM_W'(terms[3][0]);
  end

  // clip each component to the 32-bit range
  for (genvar k = 0; k < 4; k++) begin : g_sat
    always_ff @(posedge clk) begin
      if (en) begin
        if (s[k] > SUM_MAX) begin
          sum_r[k] <= COMP_MAX;
          sat_r[k] <= 1'b1;
        end else if (s[k] < SUM_MIN) begin
          sum_r[k] <= COMP_MIN;
          sat_r[k] <= 1'b1;
        end else begin
          sum_r[k] <= s[k][COMP_W-1:0];
          sat_r[k] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/quaternion_multiply_rotate.sv */
// quaternion_multiply_rotate: Q15.16 Hamilton product and vector rotation
// depends on qmr_pkg, qmr_mul_stage, qmr_sum_stage
//
//   channel   direction   handshake              payload
//   in_       input       in_valid / in_ready    in_kind, in_a_*, in_b_*
//   out_      output      out_valid / out_ready  out_r_*, out_saturated
//
// Four register stages: products, sums, products, sums. One request enters
// per cycle while in_ready is high; the two banks of sixteen 32x32
// multipliers set the stage depth.
// Synchronous active-low reset clears only the stage valid bits.
// Each stage holds while it is full and the next one cannot take its request, so a stall
// closes bubbles first and in_ready falls only when all stages are full.
`default_nettype none

module quaternion_multiply_rotate
  import qmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  comp_t       in_a_w,
  input  comp_t       in_a_x,
  input  comp_t       in_a_y,
  input  comp_t       in_a_z,
  input  comp_t       in_b_w,
  input  comp_t       in_b_x,
  input  comp_t       in_b_y,
  input  comp_t       in_b_z,
  output logic        out_valid,
  input  logic        out_ready,
  output comp_t       out_r_w,
  output comp_t       out_r_x,
  output comp_t       out_r_y,
  output comp_t       out_r_z,
  output logic        out_saturated
);

  // stage valid bits and enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // sideband carried along the stages
  logic [1:0] kind1_r, kind2_r, kind3_r, kind4_r;
  logic       flag1_r, flag2_r, flag3_r, flag4_r;
  quat_t      conj1_r, conj2_r;
  quat_t      t3_r, t4_r;

  // operand selection and conjugate
  quat_t a, v, p0, q0, conj0;
  logic  conj_clip;
  logic  rot0;

  // datapath between stages
  terms_t terms1, terms2;
  quat_t  t2, r4, p2, q2;
  logic [3:0] sat2, sat4;

  // stall chain from the output backward
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // first product operands and conjugate of a
  always_comb begin
    a = '{in_a_w, in_a_x, in_a_y, in_a_z};
    v = '{'0, in_b_x, in_b_y, in_b_z};
    rot0 = (in_kind == KIND_ROT) || (in_kind == KIND_RROT);
    conj0[0] = in_a_w;
    conj_clip = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (a[k] == COMP_MIN) begin
        conj0[k] = COMP_MAX;
        conj_clip = 1'b1;
      end else begin
        conj0[k] = -a[k];
      end
    end
    case (in_kind)
      KIND_ROT: begin
        p0 = a;
        q0 = v;
      end
      KIND_RROT: begin
        p0 = v;
        q0 = a;
      end
      default: begin
        p0 = a;
        q0 = '{in_b_w, in_b_x, in_b_y, in_b_z};
      end
    endcase
  end

  // stage 1: first products
  qmr_mul_stage u_mul1 (
    .clk     (clk),
    .en      (en1),
    .p       (p0),
    .q       (q0),
    .terms_r (terms1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1_r <= in_kind;
      flag1_r <= rot0 && conj_clip;
      conj1_r <= conj0;
    end
  end

  // stage 2: first sums, the intermediate quaternion
  qmr_sum_stage u_sum1 (
    .clk   (clk),
    .en    (en2),
    .terms (terms1),
    .sum_r (t2),
    .sat_r (sat2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      kind2_r <= kind1_r;
      flag2_r <= flag1_r;
      conj2_r <= conj1_r;
    end
  end

  // second product operands: t*conj(a) or conj(a)*t
  always_comb begin
    if (kind2_r == KIND_RROT) begin
      p2 = conj2_r;
      q2 = t2;
    end else begin
      p2 = t2;
      q2 = conj2_r;
    end
  end

  // stage 3: second products
  qmr_mul_stage u_mul2 (
    .clk     (clk),
    .en      (en3),
    .p       (p2),
    .q       (q2),
    .terms_r (terms2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      kind3_r <= kind2_r;
      flag3_r <= flag2_r || (|sat2);
      t3_r    <= t2;
    end
  end

  // stage 4: second sums, the output register
  qmr_sum_stage u_sum2 (
    .clk   (clk),
    .en    (en4),
    .terms (terms2),
    .sum_r (r4),
    .sat_r (sat4)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      kind4_r <= kind3_r;
      flag4_r <= flag3_r;
      t4_r    <= t3_r;
    end
  end

  // result selection by kind
  always_comb begin
    out_valid = v4_r;
    case (kind4_r) inside
      KIND_MUL: begin
        out_r_w       = t4_r[0];
        out_r_x       = t4_r[1];
        out_r_y       = t4_r[2];
        out_r_z       = t4_r[3];
        out_saturated = flag4_r;
      end
      KIND_ROT, KIND_RROT: begin
        out_r_w       = '0;
        out_r_x       = r4[1];
        out_r_y       = r4[2];
        out_r_z       = r4[3];
        out_saturated = flag4_r || (|sat4[3:1]);
      end
      default: begin
        out_r_w       = '0;
        out_r_x       = '0;
        out_r_y       = '0;
        out_r_z       = '0;
        out_saturated = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // an accepted request lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted request missing from stage 1");

  // a stalled stage 3 keeps its request
  a_hold3: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en3 |=> v3_r)
    else $error("stage 3 dropped a stalled request");

  // an unused kind never reports saturation and gives a zero x component
  a_none_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind4_r == KIND_NONE) |-> !out_saturated && (out_r_x == '0))
    else $error("unused kind produced a nonzero result");

  // a held output request keeps its x component and saturation flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_r_x) && $stable(out_saturated))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
